// ----- hw/rtl/ksg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Koch segment generator package
// Shared widths, configuration register indexes, controller states, the
// command and status bundles between controller and datapath, and the
// power-of-three table used for the step length.
// ----------------------------------------------------------------------------
package ksg_pkg;

    localparam int MAX_DEPTH_DEF = 8;
    localparam int MAX_DEPTH_LIM = 12;

    localparam int COORD_W    = 18;
    localparam int LEN_W      = 17;
    localparam int TRIG_W     = 16;
    localparam int DEPTH_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int FRAC_W    = 14;
    localparam int POW3_W    = 20;
    localparam int DEN_W     = POW3_W + FRAC_W;
    localparam int PROD_W    = LEN_W + 1 + TRIG_W;
    localparam int MAG_W     = PROD_W - 1;
    localparam int NUM_W     = MAG_W + 1;
    localparam int DIV_CNT_W = 6;
    localparam int VEC_W     = 20;
    localparam int ROTS_W    = 35;
    localparam int TURN_W    = 3;

    localparam logic signed [TRIG_W-1:0] ROT_SIN = 16'sd14189;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_COS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 3'd5;

    typedef enum logic [3:0] {
        S_READY,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_ROT1,
        S_ROT2,
        S_ROT3,
        S_EMIT0
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sel_y;
        logic div_load;
        logic div_step;
        logic store;
        logic rot1;
        logic rot2;
        logic rot3;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

    function automatic logic [POW3_W-1:0] pow3(input logic [DEPTH_W-1:0] d);
        logic [POW3_W-1:0] v;
        case (d)
            4'd0:    v = 20'd1;
            4'd1:    v = 20'd3;
            4'd2:    v = 20'd9;
            4'd3:    v = 20'd27;
            4'd4:    v = 20'd81;
            4'd5:    v = 20'd243;
            4'd6:    v = 20'd729;
            4'd7:    v = 20'd2187;
            4'd8:    v = 20'd6561;
            4'd9:    v = 20'd19683;
            4'd10:   v = 20'd59049;
            4'd11:   v = 20'd177147;
            4'd12:   v = 20'd531441;
            default: v = 20'd531441;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ksg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Koch segment generator controller
// Sequences the restart setup (step products, bit-serial divisions, rotated
// step vectors) and issues one emit per accepted transfer up to the last segment.
// ----------------------------------------------------------------------------
module ksg_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_restart,
    input  wire logic            i_out_stall,
    input  wire ksg_pkg::t_dp_sts i_sts,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output ksg_pkg::t_dp_cmd     o_cmd
);

    ksg_pkg::t_state                r_state;
    ksg_pkg::t_state                n_state;
    logic                           r_sel_y;
    logic [ksg_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_finished;
    logic                           r_out_valid;
    logic                           w_out_free;
    logic                           w_accept;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ksg_pkg::S_READY) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ksg_pkg::S_READY: begin
                if (w_accept && i_restart) begin
                    n_state = ksg_pkg::S_MUL;
                end
            end
            ksg_pkg::S_MUL:   n_state = ksg_pkg::S_LOAD;
            ksg_pkg::S_LOAD:  n_state = ksg_pkg::S_DIV;
            ksg_pkg::S_DIV: begin
                if (r_cnt == ksg_pkg::DIV_CNT_W'(ksg_pkg::NUM_W - 1)) begin
                    n_state = ksg_pkg::S_STORE;
                end
            end
            ksg_pkg::S_STORE: n_state = r_sel_y ? ksg_pkg::S_ROT1 : ksg_pkg::S_MUL;
            ksg_pkg::S_ROT1:  n_state = ksg_pkg::S_ROT2;
            ksg_pkg::S_ROT2:  n_state = ksg_pkg::S_ROT3;
            ksg_pkg::S_ROT3:  n_state = ksg_pkg::S_EMIT0;
            ksg_pkg::S_EMIT0: begin
                if (w_out_free) begin
                    n_state = ksg_pkg::S_READY;
                end
            end
            default:          n_state = ksg_pkg::S_READY;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.sel_y = r_sel_y;
        unique case (r_state)
            ksg_pkg::S_READY: begin
                o_cmd.load = w_accept && i_restart;
                o_cmd.emit = w_accept && !i_restart && !r_finished;
            end
            ksg_pkg::S_MUL:   o_cmd.mul      = 1'b1;
            ksg_pkg::S_LOAD:  o_cmd.div_load = 1'b1;
            ksg_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            ksg_pkg::S_STORE: o_cmd.store    = 1'b1;
            ksg_pkg::S_ROT1:  o_cmd.rot1     = 1'b1;
            ksg_pkg::S_ROT2:  o_cmd.rot2     = 1'b1;
            ksg_pkg::S_ROT3:  o_cmd.rot3     = 1'b1;
            ksg_pkg::S_EMIT0: o_cmd.emit     = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ksg_pkg::S_READY;
            r_sel_y     <= 1'b0;
            r_cnt       <= '0;
            r_finished  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_sel_y <= 1'b0;
            end else if (o_cmd.store) begin
                r_sel_y <= 1'b1;
            end
            if (o_cmd.div_load) begin
                r_cnt <= '0;
            end else if (o_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_cmd.load) begin
                r_finished <= 1'b0;
            end else if (o_cmd.emit) begin
                r_finished <= i_sts.last;
            end
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ksg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Koch segment generator datapath
// Holds the configuration registers, the step multiplier and restoring
// divider, the rotated step vectors, the pen and the segment index, and the
// segment output register.
// ----------------------------------------------------------------------------
module ksg_datapath #(
    parameter int MAX_DEPTH = ksg_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ksg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ksg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire ksg_pkg::t_dp_cmd                    i_cmd,
    output ksg_pkg::t_dp_sts                         o_sts,
    output logic signed [ksg_pkg::COORD_W-1:0]       o_seg_x0,
    output logic signed [ksg_pkg::COORD_W-1:0]       o_seg_y0,
    output logic signed [ksg_pkg::COORD_W-1:0]       o_seg_x1,
    output logic signed [ksg_pkg::COORD_W-1:0]       o_seg_y1,
    output logic                                     o_last_segment
);

    localparam int IDX_W = 2 * MAX_DEPTH;
    localparam int SUM_W = ksg_pkg::COORD_W + 3;

    function automatic logic signed [ksg_pkg::VEC_W-1:0] rnd14(
        input logic signed [ksg_pkg::ROTS_W-1:0] v
    );
        logic signed [ksg_pkg::ROTS_W-1:0] t;
        t = v + (v[ksg_pkg::ROTS_W-1] ? 35'sd8191 : 35'sd8192);
        return t[ksg_pkg::FRAC_W +: ksg_pkg::VEC_W];
    endfunction

    function automatic logic signed [ksg_pkg::COORD_W-1:0] sat18(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [ksg_pkg::COORD_W-1:0] r;
        if (v > SUM_W'(131071)) begin
            r = 18'sd131071;
        end else if (v < -SUM_W'(131072)) begin
            r = -18'sd131072;
        end else begin
            r = v[ksg_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    logic signed [ksg_pkg::COORD_W-1:0]  r_start_x;
    logic signed [ksg_pkg::COORD_W-1:0]  r_start_y;
    logic        [ksg_pkg::LEN_W-1:0]    r_len;
    logic signed [ksg_pkg::TRIG_W-1:0]   r_cos;
    logic signed [ksg_pkg::TRIG_W-1:0]   r_sin;
    logic        [ksg_pkg::DEPTH_W-1:0]  r_depth;

    logic        [ksg_pkg::DEPTH_W-1:0]  w_depth_cl;
    logic        [ksg_pkg::POW3_W-1:0]   r_pow3;
    logic        [IDX_W-1:0]             r_last_idx;

    logic signed [ksg_pkg::COORD_W-1:0]  w_mul_a;
    logic signed [ksg_pkg::TRIG_W-1:0]   w_mul_b;
    logic signed [ksg_pkg::PROD_W-1:0]   w_prod;
    logic signed [ksg_pkg::PROD_W-1:0]   r_prod;
    logic        [ksg_pkg::PROD_W-1:0]   w_abs;
    logic        [ksg_pkg::NUM_W-1:0]    w_dividend;

    logic                                r_neg;
    logic        [ksg_pkg::NUM_W-1:0]    r_quo;
    logic        [ksg_pkg::DEN_W-1:0]    r_rem;
    logic        [ksg_pkg::DEN_W-1:0]    w_den;
    logic        [ksg_pkg::DEN_W:0]      w_trial;
    logic        [ksg_pkg::DEN_W:0]      w_diff;
    logic                                w_qbit;
    logic signed [ksg_pkg::COORD_W-1:0]  w_step_sat;

    logic signed [ksg_pkg::COORD_W-1:0]  r_step_x;
    logic signed [ksg_pkg::COORD_W-1:0]  r_step_y;
    logic signed [ksg_pkg::PROD_W-1:0]   r_px;
    logic signed [ksg_pkg::PROD_W-1:0]   r_py;
    logic signed [ksg_pkg::ROTS_W-1:0]   w_sx13;
    logic signed [ksg_pkg::ROTS_W-1:0]   w_sy13;
    logic signed [ksg_pkg::ROTS_W-1:0]   w_pxe;
    logic signed [ksg_pkg::ROTS_W-1:0]   w_pye;
    logic signed [ksg_pkg::ROTS_W-1:0]   r_s_dx1;
    logic signed [ksg_pkg::ROTS_W-1:0]   r_s_dy1;
    logic signed [ksg_pkg::ROTS_W-1:0]   r_s_dx2;
    logic signed [ksg_pkg::ROTS_W-1:0]   r_s_dy2;
    logic signed [ksg_pkg::VEC_W-1:0]    r_r1x;
    logic signed [ksg_pkg::VEC_W-1:0]    r_r1y;
    logic signed [ksg_pkg::VEC_W-1:0]    r_r2x;
    logic signed [ksg_pkg::VEC_W-1:0]    r_r2y;

    logic signed [ksg_pkg::COORD_W-1:0]  r_pen_x;
    logic signed [ksg_pkg::COORD_W-1:0]  r_pen_y;
    logic        [IDX_W-1:0]             r_idx;
    logic        [ksg_pkg::TURN_W-1:0]   r_turn;
    logic        [ksg_pkg::TURN_W-1:0]   n_turn;
    logic        [1:0]                   w_digit;
    logic        [ksg_pkg::TURN_W:0]     w_turn_sum;
    logic        [ksg_pkg::TURN_W-1:0]   w_delta;

    logic signed [ksg_pkg::VEC_W-1:0]    w_vx;
    logic signed [ksg_pkg::VEC_W-1:0]    w_vy;
    logic                                w_vneg;
    logic signed [SUM_W-1:0]             w_dx;
    logic signed [SUM_W-1:0]             w_dy;
    logic signed [ksg_pkg::COORD_W-1:0]  w_x1;
    logic signed [ksg_pkg::COORD_W-1:0]  w_y1;
    logic                                w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_len     <= '0;
            r_cos     <= 16'sd16384;
            r_sin     <= '0;
            r_depth   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ksg_pkg::CFG_START_X: r_start_x <= i_cfg_data;
                ksg_pkg::CFG_START_Y: r_start_y <= i_cfg_data;
                ksg_pkg::CFG_LENGTH:  r_len     <= i_cfg_data[ksg_pkg::LEN_W-1:0];
                ksg_pkg::CFG_DIR_COS: r_cos     <= i_cfg_data[ksg_pkg::TRIG_W-1:0];
                ksg_pkg::CFG_DIR_SIN: r_sin     <= i_cfg_data[ksg_pkg::TRIG_W-1:0];
                ksg_pkg::CFG_DEPTH:   r_depth   <= i_cfg_data[ksg_pkg::DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_depth_cl = (int'(r_depth) > MAX_DEPTH) ? ksg_pkg::DEPTH_W'(MAX_DEPTH) : r_depth;

    assign w_mul_a    = $signed({1'b0, r_len});
    assign w_mul_b    = i_cmd.sel_y ? r_sin : r_cos;
    assign w_prod     = w_mul_a * w_mul_b;
    assign w_abs      = r_prod[ksg_pkg::PROD_W-1] ? ksg_pkg::PROD_W'(-r_prod)
                                                  : ksg_pkg::PROD_W'(r_prod);
    assign w_dividend = {1'b0, w_abs[ksg_pkg::MAG_W-1:0]}
                      + {1'b0, r_pow3, {(ksg_pkg::FRAC_W-1){1'b0}}};

    assign w_den   = {r_pow3, {ksg_pkg::FRAC_W{1'b0}}};
    assign w_trial = {r_rem, r_quo[ksg_pkg::NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, w_den};
    assign w_qbit  = (w_trial >= {1'b0, w_den});

    always_comb begin
        if (!r_neg) begin
            if (r_quo > ksg_pkg::NUM_W'(131071)) begin
                w_step_sat = 18'sd131071;
            end else begin
                w_step_sat = r_quo[ksg_pkg::COORD_W-1:0];
            end
        end else begin
            if (r_quo > ksg_pkg::NUM_W'(131072)) begin
                w_step_sat = -18'sd131072;
            end else begin
                w_step_sat = -$signed(r_quo[ksg_pkg::COORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pow3     <= ksg_pkg::pow3(w_depth_cl);
            r_last_idx <= ~({IDX_W{1'b1}} << {w_depth_cl, 1'b0});
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_load) begin
            r_neg <= r_prod[ksg_pkg::PROD_W-1];
            r_quo <= w_dividend;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[ksg_pkg::NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[ksg_pkg::DEN_W-1:0] : w_trial[ksg_pkg::DEN_W-1:0];
        end
        if (i_cmd.store) begin
            if (i_cmd.sel_y) begin
                r_step_y <= w_step_sat;
            end else begin
                r_step_x <= w_step_sat;
            end
        end
    end

    assign w_sx13 = {{4{r_step_x[ksg_pkg::COORD_W-1]}}, r_step_x, 13'b0};
    assign w_sy13 = {{4{r_step_y[ksg_pkg::COORD_W-1]}}, r_step_y, 13'b0};
    assign w_pxe  = {r_px[ksg_pkg::PROD_W-1], r_px};
    assign w_pye  = {r_py[ksg_pkg::PROD_W-1], r_py};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot1) begin
            r_px <= r_step_x * ksg_pkg::ROT_SIN;
            r_py <= r_step_y * ksg_pkg::ROT_SIN;
        end
        if (i_cmd.rot2) begin
            r_s_dx1 <= w_sx13 - w_pye;
            r_s_dy1 <= w_pxe + w_sy13;
            r_s_dx2 <= -w_sx13 - w_pye;
            r_s_dy2 <= w_pxe - w_sy13;
        end
        if (i_cmd.rot3) begin
            r_r1x <= rnd14(r_s_dx1);
            r_r1y <= rnd14(r_s_dy1);
            r_r2x <= rnd14(r_s_dx2);
            r_r2y <= rnd14(r_s_dy2);
        end
    end

    always_comb begin
        case (r_turn) inside
            3'd1, 3'd4: begin
                w_vx = r_r1x;
                w_vy = r_r1y;
            end
            3'd2, 3'd5: begin
                w_vx = r_r2x;
                w_vy = r_r2y;
            end
            default: begin
                w_vx = ksg_pkg::VEC_W'(r_step_x);
                w_vy = ksg_pkg::VEC_W'(r_step_y);
            end
        endcase
    end

    assign w_vneg = (r_turn >= 3'd3);
    assign w_dx   = w_vneg ? -SUM_W'(w_vx) : SUM_W'(w_vx);
    assign w_dy   = w_vneg ? -SUM_W'(w_vy) : SUM_W'(w_vy);
    assign w_x1   = sat18(SUM_W'(r_pen_x) + w_dx);
    assign w_y1   = sat18(SUM_W'(r_pen_y) + w_dy);
    assign w_last = (r_idx == r_last_idx);

    // The lowest base-4 digit that is not three is the one the increment bumps.
    always_comb begin
        w_digit = 2'd0;
        for (int j = MAX_DEPTH - 1; j >= 0; j--) begin
            if (r_idx[2*j +: 2] != 2'd3) begin
                w_digit = r_idx[2*j +: 2];
            end
        end
        case (w_digit)
            2'd1:    w_delta = 3'd2;
            default: w_delta = 3'd5;
        endcase
        w_turn_sum = {1'b0, r_turn} + {1'b0, w_delta};
        if (w_turn_sum >= 4'd6) begin
            n_turn = ksg_pkg::TURN_W'(w_turn_sum - 4'd6);
        end else begin
            n_turn = w_turn_sum[ksg_pkg::TURN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pen_x <= r_start_x;
            r_pen_y <= r_start_y;
            r_idx   <= '0;
            r_turn  <= '0;
        end else if (i_cmd.emit) begin
            r_pen_x <= w_x1;
            r_pen_y <= w_y1;
            if (!w_last) begin
                r_idx  <= r_idx + 1'b1;
                r_turn <= n_turn;
            end
        end
        if (i_cmd.emit) begin
            o_seg_x0       <= r_pen_x;
            o_seg_y0       <= r_pen_y;
            o_seg_x1       <= w_x1;
            o_seg_y1       <= w_y1;
            o_last_segment <= w_last;
        end
    end

    assign o_sts.last = w_last;

endmodule
`default_nettype wire

// ----- hw/rtl/koch_segment_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Koch segment generator
// Emits the leaf segments of a Koch curve in drawing order, one per transfer.
//
// A restart transfer latches the start point and depth and computes the leaf
// step from the length and direction. The setup runs the bit-serial divider
// once for each step component, then passes through the ROT1, ROT2 and ROT3
// states to precompute the step rotated by 60 and 120 degrees, and ends by
// emitting segment 0. After that every further transfer yields the next
// segment in the next cycle, so segments stream at one per cycle while the
// output is taken. A transfer that is not a restart after the final segment
// yields nothing. Configuration is only used by a restart and its setup.
// ----------------------------------------------------------------------------
module koch_segment_generator #(
    parameter int MAX_DEPTH = ksg_pkg::MAX_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ksg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ksg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_restart,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [ksg_pkg::COORD_W-1:0]    o_seg_x0,
    output logic signed [ksg_pkg::COORD_W-1:0]    o_seg_y0,
    output logic signed [ksg_pkg::COORD_W-1:0]    o_seg_x1,
    output logic signed [ksg_pkg::COORD_W-1:0]    o_seg_y1,
    output logic                                  o_last_segment
);

    ksg_pkg::t_dp_cmd w_cmd;
    ksg_pkg::t_dp_sts w_sts;

    ksg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    ksg_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_seg_x0       (o_seg_x0),
        .o_seg_y0       (o_seg_y0),
        .o_seg_x1       (o_seg_x1),
        .o_seg_y1       (o_seg_y1),
        .o_last_segment (o_last_segment)
    );

endmodule
`default_nettype wire

// ----- verif/koch_segment_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Koch segment generator testbench
// Sends restart and next-segment transfers with random gaps while the output
// side stalls at random. Every segment is predicted from the configured start
// point, length, direction and depth, and each output transfer is compared
// field by field. Directed tests cover the idle state after reset,
// saturation, depth clamping, and configuration held through a curve. Random
// curves follow, and the last part runs without gaps or stalls.
// ----------------------------------------------------------------------------
module koch_segment_generator_tb;

    localparam int     DEPTH_CAP     = ksg_pkg::MAX_DEPTH_DEF;
    localparam int     TOTAL_SEGS    = 950;
    localparam int     QUIET_FROM    = 780;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     CYCLE_LIMIT   = 500000;
    localparam int     MAX_REPORTS   = 60;
    localparam longint ONE_Q14       = 16384;
    localparam longint HALF_Q14      = 8192;
    localparam longint COORD_MAX     = 131071;
    localparam longint COORD_MIN     = -131072;
    localparam longint LEN_MAX       = 131071;

    localparam logic [ksg_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [ksg_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

    typedef struct packed {
        logic signed [ksg_pkg::COORD_W-1:0] x0;
        logic signed [ksg_pkg::COORD_W-1:0] y0;
        logic signed [ksg_pkg::COORD_W-1:0] x1;
        logic signed [ksg_pkg::COORD_W-1:0] y1;
        logic                               last;
    } t_seg;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [ksg_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [ksg_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic                               i_restart;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic signed [ksg_pkg::COORD_W-1:0] o_seg_x0;
    logic signed [ksg_pkg::COORD_W-1:0] o_seg_y0;
    logic signed [ksg_pkg::COORD_W-1:0] o_seg_x1;
    logic signed [ksg_pkg::COORD_W-1:0] o_seg_y1;
    logic                               o_last_segment;

    // Configuration as the block holds it.
    longint      cfg_start_x;
    longint      cfg_start_y;
    longint      cfg_length;
    longint      cfg_dir_cos;
    longint      cfg_dir_sin;
    int unsigned cfg_depth;

    // Curve state of the predictor.
    longint      curve_pen_x;
    longint      curve_pen_y;
    longint      leaf_step_x;
    longint      leaf_step_y;
    int unsigned seg_index;
    int unsigned final_index;
    bit          curve_done;

    t_seg pending_segs[$];
    t_seg arrived_seg;
    int   segs_predicted = 0;
    int   errors = 0;
    int   cycle_count = 0;
    int   in_gap = 0;
    bit   in_idle_en = 1'b0;
    bit   out_idle_en = 1'b0;
    int   out_burst = 0;

    koch_segment_generator #(
        .MAX_DEPTH(DEPTH_CAP)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seg_x0       (o_seg_x0),
        .o_seg_y0       (o_seg_y0),
        .o_seg_x1       (o_seg_x1),
        .o_seg_y1       (o_seg_y1),
        .o_last_segment (o_last_segment)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish, %0d segments still expected", $time,
                     pending_segs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Net turn of a leaf, in sixths of a full turn: digit 1 turns right,
    // digit 2 turns left.
    function automatic int unsigned leaf_turn(input int unsigned idx);
        int unsigned t;
        t = 0;
        while (idx != 0) begin
            case (idx & 3)
                1: t += 5;
                2: t += 1;
                default: ;
            endcase
            idx >>= 2;
        end
        return t % 6;
    endfunction

    function automatic void advance_curve(input logic restart);
        longint      den;
        longint      rc;
        longint      rs;
        longint      dx;
        longint      dy;
        int unsigned d;
        t_seg        seg;
        if (restart) begin
            d = (cfg_depth > DEPTH_CAP) ? DEPTH_CAP : cfg_depth;
            den = ONE_Q14;
            final_index = 0;
            repeat (d) begin
                den *= 3;
                final_index = final_index * 4 + 3;
            end
            leaf_step_x = sat_coord(div_round(cfg_length * cfg_dir_cos, den));
            leaf_step_y = sat_coord(div_round(cfg_length * cfg_dir_sin, den));
            curve_pen_x = cfg_start_x;
            curve_pen_y = cfg_start_y;
            seg_index = 0;
            curve_done = 1'b0;
        end else if (curve_done) begin
            return;
        end
        case (leaf_turn(seg_index))
            0:       begin rc = ONE_Q14;   rs = 0;                           end
            1:       begin rc = HALF_Q14;  rs = longint'(ksg_pkg::ROT_SIN);  end
            2:       begin rc = -HALF_Q14; rs = longint'(ksg_pkg::ROT_SIN);  end
            3:       begin rc = -ONE_Q14;  rs = 0;                           end
            4:       begin rc = -HALF_Q14; rs = -longint'(ksg_pkg::ROT_SIN); end
            default: begin rc = HALF_Q14;  rs = -longint'(ksg_pkg::ROT_SIN); end
        endcase
        dx = div_round(leaf_step_x * rc - leaf_step_y * rs, ONE_Q14);
        dy = div_round(leaf_step_x * rs + leaf_step_y * rc, ONE_Q14);
        seg.x0 = curve_pen_x[ksg_pkg::COORD_W-1:0];
        seg.y0 = curve_pen_y[ksg_pkg::COORD_W-1:0];
        curve_pen_x = sat_coord(curve_pen_x + dx);
        curve_pen_y = sat_coord(curve_pen_y + dy);
        seg.x1 = curve_pen_x[ksg_pkg::COORD_W-1:0];
        seg.y1 = curve_pen_y[ksg_pkg::COORD_W-1:0];
        seg.last = (seg_index >= final_index);
        pending_segs.push_back(seg);
        segs_predicted++;
        if (seg.last) begin
            curve_done = 1'b1;
        end else begin
            seg_index++;
        end
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [ksg_pkg::COORD_W-1:0] expv,
                                        input logic signed [ksg_pkg::COORD_W-1:0] actv);
        if (actv !== expv) begin
            if (errors < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            end
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                advance_curve(i_restart);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_segs.size() == 0) begin
                    if (errors < MAX_REPORTS) begin
                        $display("%0t: segment transfer, expected none, actual %0d %0d %0d %0d %0d",
                                 $time, o_seg_x0, o_seg_y0, o_seg_x1, o_seg_y1, o_last_segment);
                    end
                    errors++;
                end else begin
                    arrived_seg = pending_segs.pop_front();
                    check_field("seg_x0", arrived_seg.x0, o_seg_x0);
                    check_field("seg_y0", arrived_seg.y0, o_seg_y0);
                    check_field("seg_x1", arrived_seg.x1, o_seg_x1);
                    check_field("seg_y1", arrived_seg.y1, o_seg_y1);
                    check_field("last_segment", arrived_seg.last, o_last_segment);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!out_idle_en) begin
            i_out_stall <= 1'b0;
            out_burst = 0;
        end else if (out_burst > 0) begin
            i_out_stall <= 1'b1;
            out_burst--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            out_burst = $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic set_idling(input bit on);
        in_idle_en = on;
        out_idle_en <= on;
    endtask

    // Valid stays high after a transfer unless a gap was drawn; the caller
    // lowers it with hold_input when the stream pauses.
    task automatic send_item(input logic restart);
        if (in_gap > 0) begin
            repeat (in_gap) @(posedge i_clk);
            in_gap = 0;
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            in_gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic hold_input();
        if (in_gap == 0) begin
            i_in_valid <= 1'b0;
            in_gap = 1;
        end
    endtask

    task automatic wait_segments_done();
        while (pending_segs.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ksg_pkg::CFG_IDX_W-1:0] idx, input longint value,
                             input int width, input bit junk);
        logic [ksg_pkg::CFG_DATA_W-1:0] data;
        data = value[ksg_pkg::CFG_DATA_W-1:0];
        for (int b = width; b < ksg_pkg::CFG_DATA_W; b++) begin
            data[b] = junk ? 1'($urandom_range(0, 1)) : 1'b0;
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            ksg_pkg::CFG_START_X:
                cfg_start_x = longint'($signed(data[ksg_pkg::COORD_W-1:0]));
            ksg_pkg::CFG_START_Y:
                cfg_start_y = longint'($signed(data[ksg_pkg::COORD_W-1:0]));
            ksg_pkg::CFG_LENGTH:
                cfg_length  = longint'(data[ksg_pkg::LEN_W-1:0]);
            ksg_pkg::CFG_DIR_COS:
                cfg_dir_cos = longint'($signed(data[ksg_pkg::TRIG_W-1:0]));
            ksg_pkg::CFG_DIR_SIN:
                cfg_dir_sin = longint'($signed(data[ksg_pkg::TRIG_W-1:0]));
            ksg_pkg::CFG_DEPTH:
                cfg_depth   = data[ksg_pkg::DEPTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure_curve(input longint sx, input longint sy, input longint len,
                                   input longint dc, input longint ds, input longint dep,
                                   input bit junk);
        hold_input();
        wait_segments_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(ksg_pkg::CFG_START_X, sx, ksg_pkg::COORD_W, junk);
        write_reg(ksg_pkg::CFG_START_Y, sy, ksg_pkg::COORD_W, junk);
        write_reg(ksg_pkg::CFG_LENGTH, len, ksg_pkg::LEN_W, junk);
        write_reg(ksg_pkg::CFG_DIR_COS, dc, ksg_pkg::TRIG_W, junk);
        write_reg(ksg_pkg::CFG_DIR_SIN, ds, ksg_pkg::TRIG_W, junk);
        write_reg(ksg_pkg::CFG_DEPTH, dep, ksg_pkg::DEPTH_W, junk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_idle_after_reset();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        hold_input();
        wait_segments_done();
    endtask

    task automatic test_depth_one_curve();
        configure_curve(2560, -1280, 6912, ONE_Q14, 0, 1, 1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
    endtask

    task automatic test_saturation();
        configure_curve(COORD_MAX, COORD_MIN, LEN_MAX, -ONE_Q14, ONE_Q14, 0, 1'b0);
        send_item(1'b1);
        configure_curve(131000, -131000, LEN_MAX, ONE_Q14, -ONE_Q14, 1, 1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
    endtask

    task automatic test_depth_clamp();
        configure_curve(0, 0, LEN_MAX, 11585, 11585, 15, 1'b0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
        configure_curve(-256, 512, LEN_MAX, -11585, 11585, DEPTH_CAP, 1'b0);
        send_item(1'b1);
        repeat (2) send_item(1'b0);
    endtask

    task automatic test_config_held_mid_curve();
        configure_curve(-5000, 3000, 20000, 0, ONE_Q14, 1, 1'b0);
        send_item(1'b1);
        send_item(1'b0);
        configure_curve(7000, -9000, 50000, -ONE_Q14, 0, 0, 1'b0);
        write_reg(CFG_SPARE6, longint'($urandom), ksg_pkg::CFG_DATA_W, 1'b0);
        write_reg(CFG_SPARE7, longint'($urandom), ksg_pkg::CFG_DATA_W, 1'b0);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
    endtask

    function automatic longint rand_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return COORD_MAX;
        if (r == 1) return COORD_MIN;
        if (r < 5) return longint'($urandom_range(0, 16383)) - 8192;
        return longint'($urandom_range(0, 262143)) + COORD_MIN;
    endfunction

    task automatic random_config();
        longint      len;
        longint      dc;
        longint      ds;
        int unsigned r;
        int unsigned dep;
        r = $urandom_range(0, 9);
        if (r == 0) len = LEN_MAX;
        else if (r == 1) len = 0;
        else if (r < 5) len = $urandom_range(0, 4095);
        else len = $urandom_range(0, 131071);
        dc = longint'($urandom_range(0, 32768)) - ONE_Q14;
        if ($urandom_range(0, 5) == 0) begin
            ds = longint'($urandom_range(0, 32768)) - ONE_Q14;
        end else begin
            ds = $rtoi($sqrt(real'(ONE_Q14 * ONE_Q14) - real'(dc * dc)) + 0.5);
            if ($urandom_range(0, 1)) ds = -ds;
        end
        r = $urandom_range(0, 99);
        if (r < 15) dep = 0;
        else if (r < 42) dep = 1;
        else if (r < 70) dep = 2;
        else if (r < 84) dep = 3;
        else if (r < 88) dep = 4;
        else if (r < 96) dep = $urandom_range(5, DEPTH_CAP);
        else dep = $urandom_range(DEPTH_CAP + 1, 15);
        configure_curve(rand_coord(), rand_coord(), len, dc, ds, dep, 1'b1);
    endtask

    task automatic test_random_curves();
        int unsigned d;
        int unsigned full;
        int unsigned n_items;
        bit          first;
        first = 1'b1;
        while (segs_predicted < TOTAL_SEGS) begin
            set_idling(segs_predicted < QUIET_FROM && $urandom_range(0, 4) != 0);
            if (first || $urandom_range(0, 1)) begin
                random_config();
            end
            first = 1'b0;
            d = (cfg_depth > DEPTH_CAP) ? DEPTH_CAP : cfg_depth;
            full = (d <= 4) ? (1 << (2 * d)) : 0;
            if (d > 4) begin
                n_items = $urandom_range(5, 60);
            end else if ($urandom_range(0, 7) != 0) begin
                n_items = full;
            end else begin
                n_items = $urandom_range(1, full);
            end
            send_item(1'b1);
            for (int k = 1; k < n_items; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    hold_input();
                    wait_segments_done();
                end
                send_item(1'b0);
            end
            if (n_items == full && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(1'b0);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_restart   <= 1'b0;
        cfg_start_x = 0;
        cfg_start_y = 0;
        cfg_length  = 0;
        cfg_dir_cos = ONE_Q14;
        cfg_dir_sin = 0;
        cfg_depth   = 0;
        curve_pen_x = 0;
        curve_pen_y = 0;
        leaf_step_x = 0;
        leaf_step_y = 0;
        seg_index   = 0;
        final_index = 0;
        curve_done  = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(1'b1);

        test_idle_after_reset();
        test_depth_one_curve();
        test_saturation();
        test_depth_clamp();
        test_config_held_mid_curve();
        test_random_curves();

        hold_input();
        wait_segments_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
